### hdl/cfr_pkg.sv
// Command frame receiver package: shared types, codes and reset values.
// No dependencies; imported by every cfr module and the top level.
package cfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = 1;
  localparam int unsigned QueueCntW = 2;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_BYTE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHECKSUM_SEED = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_OPCODE = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DUMP_OPCODE = 2'd3;

  localparam logic [ByteW-1:0] SYNC_BYTE_RST = 8'hA5;
  localparam logic [ByteW-1:0] CHECKSUM_SEED_RST = 8'h33;
  localparam logic [ByteW-1:0] WRITE_OPCODE_RST = 8'hA2;
  localparam logic [ByteW-1:0] DUMP_OPCODE_RST = 8'hA3;

  // frame positions of the captured fields
  localparam logic [ByteW-1:0] POS_COMMAND = 8'd2;
  localparam logic [ByteW-1:0] POS_ADDR_HI = 8'd3;
  localparam logic [ByteW-1:0] POS_ADDR_LO = 8'd4;
  localparam logic [ByteW-1:0] POS_VALUE = 8'd5;
  localparam logic [ByteW-1:0] POS_COUNT = 8'd6;
  localparam logic [ByteW-1:0] MIN_LENGTH = 8'd2;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } parse_phase_t;

  typedef enum logic [1:0] {
    ST_GOOD  = 2'd0,
    ST_BAD   = 2'd1,
    ST_SHORT = 2'd2
  } frame_status_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DUMP  = 2'd2
  } command_kind_t;

  typedef struct packed {
    logic [ByteW-1:0] sync_byte;
    logic [ByteW-1:0] checksum_seed;
    logic [ByteW-1:0] write_opcode;
    logic [ByteW-1:0] dump_opcode;
  } cfg_t;

  // finished frame as handed from the parser to the output stage
  typedef struct packed {
    frame_status_t    status;
    logic [ByteW-1:0] length;
    logic [ByteW-1:0] command;
    logic [AddrW-1:0] address;
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] count;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### hdl/cfr_parser.sv
// Front end: hunts for sync, tracks length and running checksum, captures fields.
// Pushes one frame record per completed frame. Depends on cfr_pkg.
module cfr_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfr_pkg::cfg_t             cfg,
  input  logic                      byte_valid,
  input  logic [cfr_pkg::ByteW-1:0] rx_byte,
  output logic                      push,
  output cfr_pkg::frame_rec_t       push_rec
);
  import cfr_pkg::*;

  parse_phase_t     phase_r, phase_nxt;
  logic [ByteW-1:0] left_r, left_nxt;
  logic [ByteW-1:0] pos_r, pos_nxt;
  logic [ByteW-1:0] sum_r, sum_nxt;
  logic [ByteW-1:0] len_r, len_nxt;
  logic [ByteW-1:0] cmd_r, cmd_nxt;
  logic [AddrW-1:0] addr_r, addr_nxt;
  logic [ByteW-1:0] val_r, val_nxt;
  logic [ByteW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      left_r  <= '0;
      pos_r   <= '0;
      sum_r   <= '0;
      len_r   <= '0;
      cmd_r   <= '0;
      addr_r  <= '0;
      val_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      addr_r  <= addr_nxt;
      val_r   <= val_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    addr_nxt  = addr_r;
    val_nxt   = val_r;
    cnt_nxt   = cnt_r;
    push      = 1'b0;
    push_rec  = '{status: ST_GOOD, length: len_r, command: cmd_r, address: addr_r,
                  value: val_r, count: cnt_r};
    if (byte_valid) begin
      unique case (phase_r)
        PH_LENGTH: begin
          len_nxt = rx_byte;
          sum_nxt = sum_r + rx_byte;
          if (rx_byte < MIN_LENGTH) begin
            push            = 1'b1;
            push_rec.status = ST_SHORT;
            push_rec.length = rx_byte;
            phase_nxt       = PH_HUNT;
          end else begin
            left_nxt  = rx_byte - 8'd1;
            pos_nxt   = 8'd1;
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          pos_nxt  = pos_r + 8'd1;
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            push            = 1'b1;
            push_rec.status = (sum_r == rx_byte) ? ST_GOOD : ST_BAD;
            phase_nxt       = PH_HUNT;
          end else begin
            sum_nxt = sum_r + rx_byte;
            case (pos_nxt)
              POS_COMMAND: cmd_nxt = rx_byte;
              POS_ADDR_HI: addr_nxt = {rx_byte, addr_r[ByteW-1:0]};
              POS_ADDR_LO: addr_nxt = {addr_r[AddrW-1:ByteW], rx_byte};
              POS_VALUE:   val_nxt = rx_byte;
              POS_COUNT:   cnt_nxt = rx_byte;
              default:     ;
            endcase
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (rx_byte == cfg.sync_byte) begin
            left_nxt  = '0;
            pos_nxt   = '0;
            len_nxt   = '0;
            cmd_nxt   = '0;
            addr_nxt  = '0;
            val_nxt   = '0;
            cnt_nxt   = '0;
            sum_nxt   = cfg.checksum_seed + rx_byte;
            phase_nxt = PH_LENGTH;
          end
        end
      endcase
    end
  end

endmodule

### hdl/cfr_queue.sv
// Two-entry frame record queue between parser and output stage.
// Depends on cfr_pkg.
module cfr_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  cfr_pkg::frame_rec_t    push_rec,
  input  logic                   pop,
  output cfr_pkg::frame_rec_t    head_rec,
  output cfr_pkg::queue_status_t status
);
  import cfr_pkg::*;

  frame_rec_t           entry_r [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QueuePtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QueueCntW-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign status.full  = (cnt_r == QueueCntW'(QueueDepth));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_rec     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QueueCntW'(do_push) - QueueCntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

### hdl/cfr_output.sv
// Back end: decodes the command byte and holds the result in an output register.
// Depends on cfr_pkg.
module cfr_output (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfr_pkg::cfg_t              cfg,
  input  cfr_pkg::queue_status_t     q_status,
  input  cfr_pkg::frame_rec_t        head_rec,
  output logic                       pop,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [1:0]                 out_frame_status,
  output logic [1:0]                 out_command_kind,
  output logic [cfr_pkg::AddrW-1:0]  out_mem_address,
  output logic [cfr_pkg::ByteW-1:0]  out_write_value,
  output logic [cfr_pkg::ByteW-1:0]  out_write_count,
  output logic [cfr_pkg::ByteW-1:0]  out_frame_length
);
  import cfr_pkg::*;

  logic          valid_r, valid_nxt;
  frame_rec_t    rec_r;
  command_kind_t kind_r, kind_nxt;

  assign pop = !q_status.empty && (!valid_r || !out_stall);

  always_comb begin
    kind_nxt = KIND_OTHER;
    if (head_rec.length > MIN_LENGTH) begin
      if (head_rec.command == cfg.write_opcode) begin
        kind_nxt = KIND_WRITE;
      end else if (head_rec.command == cfg.dump_opcode) begin
        kind_nxt = KIND_DUMP;
      end
    end
    valid_nxt = pop || (valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r  <= head_rec;
      kind_r <= kind_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_frame_status = rec_r.status;
  assign out_command_kind = kind_r;
  assign out_mem_address  = rec_r.address;
  assign out_write_value  = rec_r.value;
  assign out_write_count  = rec_r.count;
  assign out_frame_length = rec_r.length;

endmodule

### hdl/command_frame_receiver.sv
// Command frame receiver top level: config registers, parser, queue, output stage.
// Depends on cfr_pkg, cfr_parser, cfr_queue, cfr_output.
//
//   channel | ports                          | transfer when
//   in      | in_valid, in_stall, in_rx_byte | in_valid && !in_stall
//   out     | out_valid, out_stall, out_*    | out_valid && !out_stall
//   cfg     | cfg_we, cfg_index, cfg_data    | cfg_we
//
// One byte per cycle while in_stall is low; parser state updates in the cycle the byte is taken.
// A result goes through a frame queue entry and the output register to out_*; out_stall can hold it.
// in_stall rises only when the two-entry frame queue is full.
// Reset is synchronous; control and config registers return to reset values, data
// registers are loaded before they are read, no clearing pass.
module command_frame_receiver (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cfr_pkg::ByteW-1:0]   in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_frame_status,
  output logic [1:0]                  out_command_kind,
  output logic [cfr_pkg::AddrW-1:0]   out_mem_address,
  output logic [cfr_pkg::ByteW-1:0]   out_write_value,
  output logic [cfr_pkg::ByteW-1:0]   out_write_count,
  output logic [cfr_pkg::ByteW-1:0]   out_frame_length,
  input  logic                        cfg_we,
  input  logic [cfr_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [cfr_pkg::ByteW-1:0]   cfg_data
);
  import cfr_pkg::*;

  cfg_t          cfg_r, cfg_nxt;
  logic          byte_take;
  logic          q_push, q_pop;
  frame_rec_t    push_rec, head_rec;
  queue_status_t q_status;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_BYTE:     cfg_nxt.sync_byte = cfg_data;
        CFG_CHECKSUM_SEED: cfg_nxt.checksum_seed = cfg_data;
        CFG_WRITE_OPCODE:  cfg_nxt.write_opcode = cfg_data;
        CFG_DUMP_OPCODE:   cfg_nxt.dump_opcode = cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{sync_byte: SYNC_BYTE_RST, checksum_seed: CHECKSUM_SEED_RST,
                 write_opcode: WRITE_OPCODE_RST, dump_opcode: DUMP_OPCODE_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall  = q_status.full;
  assign byte_take = in_valid && !in_stall;

  cfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .byte_valid (byte_take),
    .rx_byte    (in_rx_byte),
    .push       (q_push),
    .push_rec   (push_rec)
  );

  cfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head_rec (head_rec),
    .status   (q_status)
  );

  cfr_output u_output (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_status         (q_status),
    .head_rec         (head_rec),
    .pop              (q_pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_frame_status (out_frame_status),
    .out_command_kind (out_command_kind),
    .out_mem_address  (out_mem_address),
    .out_write_value  (out_write_value),
    .out_write_count  (out_write_count),
    .out_frame_length (out_frame_length)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("frame record pushed into full queue");

  a_short_has_no_command: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_status == ST_SHORT) |-> (out_command_kind == KIND_OTHER))
    else $error("short frame reported with a command");

  a_short_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_status == ST_SHORT) |-> (out_frame_length < MIN_LENGTH))
    else $error("short status with length of two or more");

  a_command_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_command_kind != KIND_OTHER) |-> (out_frame_length > MIN_LENGTH))
    else $error("command decoded from a frame without command byte");

endmodule
